// ===== rtl/grtt_pkg.sv =====
// ----------------------------------------------------------------------------
// grtt_pkg
// Shared types and fixed field widths for the grid ray tile tracer.
// ----------------------------------------------------------------------------
package grtt_pkg;

  // Item field widths
  localparam int COORD_W    = 6;   // map write column / row
  localparam int TILE_W     = 8;   // tile contents
  localparam int START_W    = 22;  // unsigned start coordinate
  localparam int DIR_W      = 24;  // signed direction component
  localparam int LIM_W      = 8;   // step limit
  localparam int OUT_W      = 2;   // outcome code
  localparam int HIT_W      = 6;   // reported hit column / row

  // Minor slope: (minor << STEP_SHIFT) / (major >> STEP_SHIFT)
  localparam int STEP_SHIFT = 8;
  localparam int DVD_W      = DIR_W + STEP_SHIFT;  // dividend magnitude
  localparam int DVS_W      = DIR_W - STEP_SHIFT;  // divisor
  localparam int QUO_W      = DVD_W + 1;           // signed minor step
  localparam int POS_W      = QUO_W + 1;           // signed minor position

  typedef logic [OUT_W-1:0] outcome_t;

  localparam outcome_t OUT_NONE = 2'd0;  // limit ran out
  localparam outcome_t OUT_HIT  = 2'd1;  // non-empty tile found
  localparam outcome_t OUT_LEFT = 2'd2;  // walked off the map

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TRACE = 1'b1;

endpackage

// ===== rtl/grtt_div.sv =====
// ----------------------------------------------------------------------------
// grtt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grtt_div
  import grtt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;   // shifts out dividend, shifts in quotient
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== rtl/grid_ray_tile_trace_top.sv =====
// ----------------------------------------------------------------------------
// grid_ray_tile_trace_top
// Fixed-point ray walk over a square tile map held in on-chip memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | carries
//  --------+-----------+--------------------+-----------------------------------
//  in_     | in        | in_valid/in_stall  | map tile write or trace request
//  out_    | out       | out_valid/out_stall| outcome and hit tile, one per trace
//
// Flow: a map write is taken and the next item may follow at once. A trace
//   runs the serial slope divider, then ADV/CHK/MAIN for each tile step walked,
//   with CRN added for each corner tile probed. The single tile-memory read
//   port is the per-step limit.
// Reset: synchronous active-low; clears control and walk registers. The tile
//   memory is not cleared, and a trace must only reach tiles written before.
// Stalls: a finished result sits in the output register; new items, including
//   map writes, are taken while it waits. A second trace can finish only
//   once the previous result is transferred.
//
module grid_ray_tile_trace_top
  import grtt_pkg::*;
#(
  parameter int MAP_SIZE       = 64,
  parameter int TILE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [COORD_W-1:0]  in_map_col,
  input  logic [COORD_W-1:0]  in_map_row,
  input  logic [TILE_W-1:0]   in_tile_value,
  input  logic [START_W-1:0]  in_start_x,
  input  logic [START_W-1:0]  in_start_y,
  input  logic signed [DIR_W-1:0] in_dir_x,
  input  logic signed [DIR_W-1:0] in_dir_y,
  input  logic [LIM_W-1:0]    in_step_limit,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_W-1:0]    out_outcome,
  output logic [HIT_W-1:0]    out_hit_col,
  output logic [HIT_W-1:0]    out_hit_row
);

  localparam int IW        = $clog2(MAP_SIZE);        // tile index bits
  localparam int MEM_DEPTH = 1 << (2 * IW);
  localparam int MJW       = START_W - TILE_FRAC_BITS + 2;  // signed major tile
  localparam int MTW       = POS_W - TILE_FRAC_BITS;        // signed minor tile

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take items
  localparam logic [2:0] S_SEL  = 3'd1;  // pick axes, launch divider
  localparam logic [2:0] S_DIV  = 3'd2;  // wait for slope
  localparam logic [2:0] S_ADV  = 3'd3;  // step one tile on the major axis
  localparam logic [2:0] S_CHK  = 3'd4;  // issue corner or main tile read
  localparam logic [2:0] S_CRN  = 3'd5;  // corner data back, maybe read main
  localparam logic [2:0] S_MAIN = 3'd6;  // main tile data back
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to output register

  logic [2:0] state_r, state_nxt;

  // --------------------------------------------------------------------------
  // Input transfer and trace request capture
  // --------------------------------------------------------------------------
  logic in_xfer;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  logic [START_W-1:0]      sx_r, sy_r;
  logic [DIR_W-1:0]        dx_r, dy_r;
  logic [LIM_W-1:0]        limit_r;

  always_ff @(posedge clk) begin
    if (in_xfer && in_func == FUNC_TRACE) begin
      sx_r    <= in_start_x;
      sy_r    <= in_start_y;
      dx_r    <= in_dir_x;
      dy_r    <= in_dir_y;
      limit_r <= in_step_limit;
    end
  end

  // --------------------------------------------------------------------------
  // Tile memory: written by map items, read by the walk, registered read
  // --------------------------------------------------------------------------
  logic                wr_en;
  logic [2*IW-1:0]     wr_addr;
  logic                rd_en;
  logic [2*IW-1:0]     rd_addr;
  logic [TILE_W-1:0]   rd_data_r;
  logic [TILE_W-1:0]   tile_mem [0:MEM_DEPTH-1];

  // Writes outside the map are dropped
  assign wr_en   = in_xfer && (in_func == FUNC_WRITE)
                   && (32'(in_map_col) < 32'(MAP_SIZE))
                   && (32'(in_map_row) < 32'(MAP_SIZE));
  assign wr_addr = {IW'(in_map_col), IW'(in_map_row)};

  always_ff @(posedge clk) begin
    if (wr_en)
      tile_mem[wr_addr] <= in_tile_value;
    if (rd_en)
      rd_data_r <= tile_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Axis selection (S_SEL)
  // --------------------------------------------------------------------------
  logic [DIR_W-1:0] adx, ady, amaj, amin;
  logic             sel_x_major;
  logic [DVS_W-1:0] maj_shr;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_dividend;
  logic             sel_min_neg, sel_maj_neg;

  assign adx         = dx_r[DIR_W-1] ? (~dx_r + 1'b1) : dx_r;
  assign ady         = dy_r[DIR_W-1] ? (~dy_r + 1'b1) : dy_r;
  assign sel_x_major = adx > ady;            // tie goes to y
  assign amaj        = sel_x_major ? adx : ady;
  assign amin        = sel_x_major ? ady : adx;
  assign sel_min_neg = sel_x_major ? dy_r[DIR_W-1] : dx_r[DIR_W-1];
  assign sel_maj_neg = sel_x_major ? dx_r[DIR_W-1] : dy_r[DIR_W-1];
  assign maj_shr     = amaj[DIR_W-1:STEP_SHIFT];
  assign div_divisor = (maj_shr == '0) ? DVS_W'(1) : maj_shr;
  assign div_dividend = {amin, {STEP_SHIFT{1'b0}}};

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  grtt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Per-trace flags
  logic x_major_r;     // x is the major axis
  logic dirpos_r;      // major axis walks upward
  logic min_pos_r;     // minor delta > 0
  logic min_neg_r;     // minor delta < 0

  always_ff @(posedge clk) begin
    if (state_r == S_SEL) begin
      x_major_r <= sel_x_major;
      dirpos_r  <= !sel_maj_neg && (amaj != '0);
      min_pos_r <= !sel_min_neg && (amin != '0);
      min_neg_r <= sel_min_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Walk registers
  // --------------------------------------------------------------------------
  logic [MJW-1:0]    pos_major_r,  pos_major_nxt;   // signed tile on major axis
  logic [POS_W-1:0]  pos_minor_r,  pos_minor_nxt;   // signed fixed-point minor
  logic [IW-1:0]     last_minor_r, last_minor_nxt;  // minor tile last visited
  logic [LIM_W-1:0]  steps_left_r, steps_left_nxt;
  logic              first_r,      first_nxt;       // first step: no corner
  logic [QUO_W-1:0]  q_r,          q_nxt;           // signed minor step
  logic [MJW-1:0]    probe_maj_r,  probe_maj_nxt;
  logic [MTW-1:0]    probe_min_r,  probe_min_nxt;
  outcome_t          res_outcome_r, res_outcome_nxt;
  logic [HIT_W-1:0]  res_col_r,    res_col_nxt;
  logic [HIT_W-1:0]  res_row_r,    res_row_nxt;

  // Current minor tile is the floor of the position: just the upper bits
  logic [MTW-1:0] mt;
  logic [MTW-1:0] last_minor_ext;
  logic [MJW-1:0] corner_maj;
  logic [MTW-1:0] corner_min;
  logic           corner_sel;
  logic [MJW-1:0] probe_maj;
  logic [MTW-1:0] probe_min;
  logic           probe_ok;
  logic           tile_hit;

  assign mt             = pos_minor_r[POS_W-1:TILE_FRAC_BITS];
  assign last_minor_ext = MTW'(last_minor_r);
  // Corner between old and new minor tile, on the lower-numbered major tile
  assign corner_maj     = dirpos_r ? (pos_major_r - MJW'(1)) : pos_major_r;
  assign corner_min     = dirpos_r ? mt : last_minor_ext;
  assign corner_sel     = (state_r == S_CHK) && !first_r && (mt != last_minor_ext);
  assign probe_maj      = corner_sel ? corner_maj : pos_major_r;
  assign probe_min      = corner_sel ? corner_min : mt;
  assign probe_ok       = !probe_maj[MJW-1] && (32'(probe_maj) < 32'(MAP_SIZE))
                          && !probe_min[MTW-1] && (32'(probe_min) < 32'(MAP_SIZE));
  assign rd_addr        = x_major_r ? {IW'(probe_maj), IW'(probe_min)}
                                    : {IW'(probe_min), IW'(probe_maj)};
  assign tile_hit       = (rd_data_r != '0);

  // Quotient sign fix-up: zero slope is forced to +1 or -1
  logic [QUO_W-1:0] q_mag;
  assign q_mag = {1'b0, div_quot};

  logic out_load;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt       = state_r;
    pos_major_nxt   = pos_major_r;
    pos_minor_nxt   = pos_minor_r;
    last_minor_nxt  = last_minor_r;
    steps_left_nxt  = steps_left_r;
    first_nxt       = first_r;
    q_nxt           = q_r;
    probe_maj_nxt   = probe_maj_r;
    probe_min_nxt   = probe_min_r;
    res_outcome_nxt = res_outcome_r;
    res_col_nxt     = res_col_r;
    res_row_nxt     = res_row_r;
    div_start       = 1'b0;
    rd_en           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_func == FUNC_TRACE)
          state_nxt = S_SEL;
      end

      S_SEL: begin
        div_start      = 1'b1;
        pos_major_nxt  = sel_x_major ? MJW'(sx_r >> TILE_FRAC_BITS)
                                     : MJW'(sy_r >> TILE_FRAC_BITS);
        pos_minor_nxt  = sel_x_major ? POS_W'(sy_r) : POS_W'(sx_r);
        steps_left_nxt = limit_r;
        first_nxt      = 1'b1;
        state_nxt      = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          if (div_quot == '0)
            q_nxt = min_pos_r ? QUO_W'(1) : {QUO_W{1'b1}};
          else
            q_nxt = min_neg_r ? (~q_mag + 1'b1) : q_mag;
          state_nxt = S_ADV;
        end
      end

      S_ADV: begin
        pos_major_nxt = dirpos_r ? (pos_major_r + MJW'(1)) : (pos_major_r - MJW'(1));
        pos_minor_nxt = pos_minor_r + {{(POS_W-QUO_W){q_r[QUO_W-1]}}, q_r};
        state_nxt     = S_CHK;
      end

      S_CHK: begin
        first_nxt = 1'b0;
        if (!corner_sel)
          last_minor_nxt = IW'(mt);
        if (!probe_ok) begin
          res_outcome_nxt = OUT_LEFT;
          res_col_nxt     = '0;
          res_row_nxt     = '0;
          state_nxt       = S_DONE;
        end else begin
          rd_en         = 1'b1;
          probe_maj_nxt = probe_maj;
          probe_min_nxt = probe_min;
          state_nxt     = corner_sel ? S_CRN : S_MAIN;
        end
      end

      S_CRN: begin
        if (tile_hit) begin
          res_outcome_nxt = OUT_HIT;
          res_col_nxt     = x_major_r ? HIT_W'(probe_maj_r) : HIT_W'(probe_min_r);
          res_row_nxt     = x_major_r ? HIT_W'(probe_min_r) : HIT_W'(probe_maj_r);
          state_nxt       = S_DONE;
        end else begin
          last_minor_nxt = IW'(mt);
          if (!probe_ok) begin
            res_outcome_nxt = OUT_LEFT;
            res_col_nxt     = '0;
            res_row_nxt     = '0;
            state_nxt       = S_DONE;
          end else begin
            rd_en         = 1'b1;
            probe_maj_nxt = probe_maj;
            probe_min_nxt = probe_min;
            state_nxt     = S_MAIN;
          end
        end
      end

      S_MAIN: begin
        if (tile_hit) begin
          res_outcome_nxt = OUT_HIT;
          res_col_nxt     = x_major_r ? HIT_W'(probe_maj_r) : HIT_W'(probe_min_r);
          res_row_nxt     = x_major_r ? HIT_W'(probe_min_r) : HIT_W'(probe_maj_r);
          state_nxt       = S_DONE;
        end else if (steps_left_r != '0) begin
          // zero limit never reaches here with a nonzero count: unlimited walk
          steps_left_nxt = steps_left_r - 1'b1;
          if (steps_left_r == LIM_W'(1)) begin
            res_outcome_nxt = OUT_NONE;
            res_col_nxt     = '0;
            res_row_nxt     = '0;
            state_nxt       = S_DONE;
          end else begin
            state_nxt = S_ADV;
          end
        end else begin
          state_nxt = S_ADV;
        end
      end

      S_DONE: begin
        if (out_load)
          state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_major_r  <= '0;
      pos_minor_r  <= '0;
      last_minor_r <= '0;
      steps_left_r <= '0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_major_r  <= pos_major_nxt;
      pos_minor_r  <= pos_minor_nxt;
      last_minor_r <= last_minor_nxt;
      steps_left_r <= steps_left_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r           <= q_nxt;
    probe_maj_r   <= probe_maj_nxt;
    probe_min_r   <= probe_min_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_col_r     <= res_col_nxt;
    res_row_r     <= res_row_nxt;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic              out_valid_r, out_valid_nxt;
  outcome_t          out_outcome_r;
  logic [HIT_W-1:0]  out_hit_col_r, out_hit_row_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)
      out_valid_nxt = 1'b1;
    else if (!out_stall)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_outcome_r <= res_outcome_r;
      out_hit_col_r <= res_col_r;
      out_hit_row_r <= res_row_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_hit_col = out_hit_col_r;
  assign out_hit_row = out_hit_row_r;

endmodule

// ===== rtl/grtt_chk.sv =====
// ----------------------------------------------------------------------------
// grtt_chk
// Port-level checks for the grid ray tile tracer, bound to the top level.
// ----------------------------------------------------------------------------
module grtt_chk
  import grtt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_func,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OUT_W-1:0]  out_outcome,
  input logic [HIT_W-1:0]  out_hit_col,
  input logic [HIT_W-1:0]  out_hit_row
);

  // A trace occupies the block: the next item waits
  a_trace_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_TRACE |=> in_stall)
    else $error("trace transfer did not hold off the input");

  // A map write does not hold off the next item
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_WRITE |=> !in_stall)
    else $error("map write held off the input");

  // A new result only appears while a trace is in flight
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a trace in flight");

  // Hit coordinates are zero unless a tile was hit
  a_coord_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OUT_HIT |-> out_hit_col == '0 && out_hit_row == '0)
    else $error("nonzero hit tile on a miss");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_outcome)
                               && $stable(out_hit_col) && $stable(out_hit_row))
    else $error("stalled result changed");

endmodule

bind grid_ray_tile_trace_top grtt_chk u_grtt_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_func     (in_func),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_outcome (out_outcome),
  .out_hit_col (out_hit_col),
  .out_hit_row (out_hit_row)
);
